/* hdl/cdq_pkg.sv */
// Shared types and constants for the circular deque unit.
package cdq_pkg;

    // Request codes carried in the input tuser field
    localparam int REQ_W = 3;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    // Field widths of the stream words
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 11;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 112;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic take;   // latch the incoming word
        logic exec;   // apply the request to store and pointers
        logic rd;     // read front and back entries
        logic load;   // refresh cached ends and fill the output register
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;  // output register still holds an untaken word
    } t_ctl_sts;

endpackage

/* hdl/cdq_ctrl.sv */
// Sequencing state machine of the circular deque unit.
module cdq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cdq_pkg::t_ctl_sts   i_sts,
    output cdq_pkg::t_ctl_cmd   o_cmd
);
    import cdq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // refuse words while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                // hold until the previous result word has left
                if (!i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* hdl/cdq_datapath.sv */
// Ring store, pointers, element count and result register of the deque.
module cdq_datapath #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdq_pkg::t_ctl_cmd           i_cmd,
    output cdq_pkg::t_ctl_sts           o_sts,
    input  logic [cdq_pkg::REQ_W-1:0]   i_req,
    input  logic [cdq_pkg::VAL_W-1:0]   i_push_value,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [cdq_pkg::OUT_W-1:0]   o_tdata
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [REQ_W-1:0]      r_req;
    logic [DATA_WIDTH-1:0] r_val;
    logic [AW-1:0]         r_front;
    logic [AW-1:0]         r_back;
    logic [CW-1:0]         r_count;
    logic [DATA_WIDTH-1:0] r_front_val;
    logic [DATA_WIDTH-1:0] r_back_val;
    logic [DATA_WIDTH-1:0] r_rd_front;
    logic [DATA_WIDTH-1:0] r_rd_back;
    logic [DATA_WIDTH-1:0] r_pop_val;
    logic                  r_pop_vld;
    logic                  r_empty_err;
    logic                  r_full_err;
    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out;

    logic [AW-1:0] front_up, front_dn, back_up, back_dn;
    logic          is_push, is_pop, is_full, is_emp;
    logic          do_push_f, do_push_b, do_pop_f, do_pop_b;
    logic [63:0]   push_ext, pop_ext, front_ext, back_ext;
    logic [CW+CNT_W-1:0] cnt_ext;
    logic [VAL_W-1:0] front_out, back_out;
    logic          emp_after;

    assign front_up = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign front_dn = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign back_up  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;
    assign back_dn  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;

    assign is_push = (r_req == REQ_PUSH_FRONT) || (r_req == REQ_PUSH_BACK);
    assign is_pop  = (r_req == REQ_POP_FRONT) || (r_req == REQ_POP_BACK);
    assign is_full = (r_count == FULL_CNT);
    assign is_emp  = (r_count == '0);

    assign do_push_f = i_cmd.exec && (r_req == REQ_PUSH_FRONT) && !is_full;
    assign do_push_b = i_cmd.exec && (r_req == REQ_PUSH_BACK) && !is_full;
    assign do_pop_f  = i_cmd.exec && (r_req == REQ_POP_FRONT) && !is_emp;
    assign do_pop_b  = i_cmd.exec && (r_req == REQ_POP_BACK) && !is_emp;

    assign push_ext = 64'(i_push_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_req;
            r_val <= push_ext[DATA_WIDTH-1:0];
        end
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (do_push_f) begin
            r_mem[front_dn] <= r_val;
        end else if (do_push_b) begin
            r_mem[r_back] <= r_val;
        end
        if (i_cmd.rd) begin
            r_rd_front <= r_mem[r_front];
            r_rd_back  <= r_mem[back_dn];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            if (do_push_f) begin
                r_front <= front_dn;
                r_count <= r_count + 1'b1;
            end else if (do_push_b) begin
                r_back  <= back_up;
                r_count <= r_count + 1'b1;
            end else if (do_pop_f) begin
                r_front <= front_up;
                r_count <= r_count - 1'b1;
            end else if (do_pop_b) begin
                r_back  <= back_dn;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // popped value comes from the cached ends, valid whenever not empty
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pop_vld   <= do_pop_f || do_pop_b;
            r_empty_err <= is_pop && is_emp;
            r_full_err  <= is_push && is_full;
            if (do_pop_f) begin
                r_pop_val <= r_front_val;
            end else if (do_pop_b) begin
                r_pop_val <= r_back_val;
            end else begin
                r_pop_val <= '0;
            end
        end
        if (i_cmd.load) begin
            r_front_val <= r_rd_front;
            r_back_val  <= r_rd_back;
        end
    end

    assign pop_ext   = 64'(r_pop_val);
    assign front_ext = 64'(r_rd_front);
    assign back_ext  = 64'(r_rd_back);
    assign cnt_ext   = (CW + CNT_W)'(r_count);
    assign emp_after = is_emp;
    assign front_out = emp_after ? '0 : front_ext[VAL_W-1:0];
    assign back_out  = emp_after ? '0 : back_ext[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= {1'b0, back_out, front_out, emp_after, cnt_ext[CNT_W-1:0],
                      r_full_err, r_empty_err, r_pop_vld, pop_ext[VAL_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_sts.out_busy = r_out_vld && !i_tready;
    assign o_tvalid       = r_out_vld;
    assign o_tdata        = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count beyond capacity");

    a_ptr_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front == r_back) |-> (r_count == '0 || r_count == FULL_CNT))
        else $error("pointers equal with partial fill");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop_f || do_pop_b) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drop the count by one");

    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_full_err) |-> is_full)
        else $error("full error reported below capacity");
`endif

endmodule

/* hdl/circular_deque_unit.sv */
// Top level of the circular deque unit: controller and datapath.
//
// A double-ended queue of DEPTH entries in a ring store. Each input word is
// one request (push front, push back, pop front, pop back, query; codes 5 to
// 7 act as query) and yields exactly one result word. Each word passes through
// accept, execute (store write and pointer update), a two-port read
// of the front and back entries, and the load of the result register; the
// load waits while the previous result is still held downstream. A push on
// a full deque and a pop on an empty one change nothing and set full_error
// or empty_error. The store needs no clearing after reset.
module circular_deque_unit #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [31:0] push_value
    input  logic [cdq_pkg::IN_W-1:0]    i_s_axis_tdata,
    // [2:0] req_type
    input  logic [cdq_pkg::REQ_W-1:0]   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [31:0] pop_value, [32] pop_valid, [33] empty_error, [34] full_error,
    // [45:35] element_count, [46] is_empty, [78:47] front_value,
    // [110:79] back_value, [111] zero
    output logic [cdq_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import cdq_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req        (i_s_axis_tuser),
        .i_push_value (i_s_axis_tdata),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata)
    );

endmodule

/* tb/circular_deque_unit_test.sv */
// Self-checking stream testbench for the circular deque unit with its own deque predictor.
module circular_deque_unit_test;
    import cdq_pkg::*;

    localparam int RING_DEPTH   = 1024;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int CALM_START   = 2000;
    localparam int CALM_END     = 6000;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [VAL_W-1:0] value;
    } t_deque_req;

    typedef struct packed {
        logic [VAL_W-1:0] pop_value;
        logic             pop_valid;
        logic             empty_error;
        logic             full_error;
        logic [CNT_W-1:0] element_count;
        logic             is_empty;
        logic [VAL_W-1:0] front_value;
        logic [VAL_W-1:0] back_value;
    } t_deque_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [IN_W-1:0]  s_data = '0;
    logic [REQ_W-1:0] s_req = REQ_QUERY;
    logic             m_ready = 1'b1;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;

    circular_deque_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_req),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_deque_req   request_q[$];
    t_deque_reply reply_q[$];
    t_deque_req   next_word;
    t_deque_reply want;
    int           mismatch_cnt = 0;
    int           cycle_cnt = 0;
    int           gen_fill = 0;

    // Shadow copy of the deque
    logic [VAL_W-1:0]   ring_mem [RING_DEPTH];
    logic [RING_AW-1:0] ring_front = '0;
    logic [RING_AW-1:0] ring_back = '0;
    logic               ring_pushed = 1'b0;

    function automatic logic [CNT_W-1:0] ring_count();
        logic [RING_AW-1:0] span;
        span = ring_back - ring_front;
        if (span == '0)
            return ring_pushed ? CNT_W'(RING_DEPTH) : '0;
        return CNT_W'(span);
    endfunction

    function automatic t_deque_reply predict_reply(logic [REQ_W-1:0] req,
                                                   logic [VAL_W-1:0] value);
        t_deque_reply r;
        logic [CNT_W-1:0] cnt;
        r = '0;
        cnt = ring_count();
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (cnt == CNT_W'(RING_DEPTH)) begin
                    r.full_error = 1'b1;
                end else if (req == REQ_PUSH_FRONT) begin
                    ring_front = ring_front - 1'b1;
                    ring_mem[ring_front] = value;
                    ring_pushed = 1'b1;
                end else begin
                    ring_mem[ring_back] = value;
                    ring_back = ring_back + 1'b1;
                    ring_pushed = 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (cnt == '0) begin
                    r.empty_error = 1'b1;
                end else if (req == REQ_POP_FRONT) begin
                    r.pop_value = ring_mem[ring_front];
                    ring_front = ring_front + 1'b1;
                    r.pop_valid = 1'b1;
                    ring_pushed = 1'b0;
                end else begin
                    ring_back = ring_back - 1'b1;
                    r.pop_value = ring_mem[ring_back];
                    r.pop_valid = 1'b1;
                    ring_pushed = 1'b0;
                end
            end
            default: ;  // query and unused codes change nothing
        endcase
        cnt = ring_count();
        r.element_count = cnt;
        r.is_empty = (cnt == '0);
        if (cnt != '0) begin
            r.front_value = ring_mem[ring_front];
            r.back_value = ring_mem[ring_back - 1'b1];
        end
        return r;
    endfunction

    function automatic bit take_gap();
        if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END)
            return 1'b0;
        return ($urandom_range(99) < 13);
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatch_cnt = mismatch_cnt + 1;
        end
    endtask

    // Track the fill level while building the stimulus so phases can aim at deep and empty
    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] value);
        t_deque_req w;
        w.req = req;
        w.value = value;
        request_q = {request_q, w};
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: if (gen_fill < RING_DEPTH) gen_fill++;
            REQ_POP_FRONT, REQ_POP_BACK:   if (gen_fill > 0) gen_fill--;
            default: ;
        endcase
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_request(input int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            queue_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, rand_value());
        else if (roll < push_pct + 6)
            queue_request(REQ_W'($urandom_range(7, 4)), rand_value());
        else
            queue_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, rand_value());
    endtask

    // Driver: hold the word until taken, then predict it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready)
                reply_q = {reply_q, predict_reply(s_req, s_data)};
            if (!s_valid || o_s_axis_tready) begin
                if (request_q.size() != 0 && !take_gap()) begin
                    next_word = request_q[0];
                    request_q.delete(0);
                    s_req   <= next_word.req;
                    s_data  <= next_word.value;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (reply_q.size() == 0) begin
                $error("result word with no prediction pending: %h", o_m_axis_tdata);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                want = reply_q[0];
                reply_q.delete(0);
                check_field("pop_value", want.pop_value, o_m_axis_tdata[31:0]);
                check_field("pop_valid", 32'(want.pop_valid), 32'(o_m_axis_tdata[32]));
                check_field("empty_error", 32'(want.empty_error), 32'(o_m_axis_tdata[33]));
                check_field("full_error", 32'(want.full_error), 32'(o_m_axis_tdata[34]));
                check_field("element_count", 32'(want.element_count),
                            32'(o_m_axis_tdata[45:35]));
                check_field("is_empty", 32'(want.is_empty), 32'(o_m_axis_tdata[46]));
                check_field("front_value", want.front_value, o_m_axis_tdata[78:47]);
                check_field("back_value", want.back_value, o_m_axis_tdata[110:79]);
                check_field("pad", 32'h0, 32'(o_m_axis_tdata[111]));
            end
        end
        m_ready <= !take_gap();
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("circular_deque_unit: mismatch");
            $finish;
        end
    end

    initial begin
        // Directed: empty pops, extreme values, both ends, wrap below index zero
        queue_request(REQ_QUERY, 32'h1234_5678);
        queue_request(REQ_POP_FRONT, 32'h0);
        queue_request(REQ_POP_BACK, 32'hffff_ffff);
        queue_request(REQ_PUSH_FRONT, 32'h7fff_ffff);
        queue_request(REQ_PUSH_BACK, 32'h8000_0000);
        queue_request(REQ_PUSH_FRONT, 32'h0000_0000);
        queue_request(REQ_PUSH_BACK, 32'hffff_ffff);
        queue_request(REQ_QUERY, 32'h0);
        queue_request(REQ_POP_FRONT, 32'h0);
        queue_request(REQ_POP_BACK, 32'h0);
        queue_request(REQ_POP_BACK, 32'h0);
        queue_request(REQ_POP_FRONT, 32'h0);
        queue_request(REQ_POP_BACK, 32'h0);
        queue_request(REQ_PUSH_BACK, 32'h0000_0005);
        queue_request(REQ_W'(5), 32'hdead_beef);
        queue_request(REQ_W'(6), 32'h5555_aaaa);
        queue_request(REQ_W'(7), 32'haaaa_5555);
        queue_request(REQ_PUSH_FRONT, 32'ha5a5_a5a5);
        queue_request(REQ_POP_BACK, 32'h0);
        queue_request(REQ_POP_FRONT, 32'h0);
        queue_request(REQ_POP_FRONT, 32'h0);

        repeat (120) add_random_request(47);
        // Push-heavy stretch to a deep fill, then work both ends
        repeat (230) add_random_request(90);
        queue_request(REQ_PUSH_FRONT, rand_value());
        queue_request(REQ_PUSH_BACK, rand_value());
        queue_request(REQ_QUERY, rand_value());
        queue_request(REQ_POP_FRONT, rand_value());
        queue_request(REQ_PUSH_BACK, rand_value());
        queue_request(REQ_PUSH_FRONT, rand_value());
        queue_request(REQ_POP_BACK, rand_value());
        queue_request(REQ_PUSH_FRONT, rand_value());
        queue_request(REQ_PUSH_BACK, rand_value());
        // Drain to empty, then pop past the bottom
        while (gen_fill > 0) add_random_request(8);
        queue_request(REQ_POP_FRONT, rand_value());
        queue_request(REQ_POP_BACK, rand_value());
        queue_request(REQ_QUERY, rand_value());
        repeat (110) add_random_request(47);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || s_valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("circular_deque_unit: match");
        else
            $display("circular_deque_unit: mismatch");
        $finish;
    end

endmodule
